@@ rtl/pru_pkg.sv @@
// package for the palette register unit
// holds bus addresses, function and table codes, widths and the mono shade table
// no dependencies
package pru_pkg;

  localparam int COLOR_WORDS = 32;
  localparam int WORD_AW     = $clog2(COLOR_WORDS);

  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int TBL_W  = 3;
  localparam int PAL_W  = 3;
  localparam int CI_W   = 2;
  localparam int IDX_W  = 6;
  localparam int RGB_W  = 16;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_t;

  localparam logic [TBL_W-1:0] TBL_MONO_BG   = 3'd0;
  localparam logic [TBL_W-1:0] TBL_MONO_OBJ0 = 3'd1;
  localparam logic [TBL_W-1:0] TBL_MONO_OBJ1 = 3'd2;
  localparam logic [TBL_W-1:0] TBL_COLOR_BG  = 3'd3;
  localparam logic [TBL_W-1:0] TBL_COLOR_OBJ = 3'd4;

  localparam logic [ADDR_W-1:0] ADDR_MONO_BG   = 16'hFF47;
  localparam logic [ADDR_W-1:0] ADDR_MONO_OBJ0 = 16'hFF48;
  localparam logic [ADDR_W-1:0] ADDR_MONO_OBJ1 = 16'hFF49;
  localparam logic [ADDR_W-1:0] ADDR_BG_INDEX  = 16'hFF68;
  localparam logic [ADDR_W-1:0] ADDR_BG_DATA   = 16'hFF69;
  localparam logic [ADDR_W-1:0] ADDR_OBJ_INDEX = 16'hFF6A;
  localparam logic [ADDR_W-1:0] ADDR_OBJ_DATA  = 16'hFF6B;

  // shades 0,1,2,3 packed two bits each
  localparam logic [BYTE_W-1:0] MONO_RESET = 8'hE4;

  function automatic logic [RGB_W-1:0] shade_rgb(input logic [1:0] shade);
    logic [RGB_W-1:0] rgb;
    case (shade)
      2'd0:    rgb = 16'hFFFF;
      2'd1:    rgb = 16'hAD55;
      2'd2:    rgb = 16'h52AA;
      default: rgb = 16'h0000;
    endcase
    return rgb;
  endfunction

endpackage

@@ rtl/pru_color_fix.sv @@
// colour correction from a stored 15-bit colour word to rgb565
// depends on pru_pkg
module pru_color_fix (
  input  logic [pru_pkg::RGB_W-1:0] word_i,
  output logic [pru_pkg::RGB_W-1:0] rgb_o
);
  import pru_pkg::*;

  logic [4:0] r;
  logic [4:0] g;
  logic [4:0] b;
  logic [8:0] hi_sum;
  logic [6:0] mid_sum;
  logic [8:0] lo_sum;

  always_comb begin
    r = word_i[4:0];
    g = word_i[9:5];
    b = word_i[14:10];
    hi_sum  = 9'(r) * 9'd13 + 9'(g) * 9'd2 + 9'(b) + 9'd8;
    mid_sum = 7'(g) * 7'd3 + 7'(b) + 7'd1;
    lo_sum  = 9'(r) * 9'd3 + 9'(g) * 9'd2 + 9'(b) * 9'd11 + 9'd8;
    rgb_o   = {hi_sum[8:4], mid_sum[6:1], lo_sum[8:4]};
  end

endmodule

@@ rtl/palette_register_unit.sv @@
// top level of the palette register unit: input register, register file and result register
// depends on pru_pkg and pru_color_fix
//
// Accepts one bus access (read, write) or colour lookup per clock and returns
// exactly one result per item, in order. An accepted item sits in the input
// register, where the register file is read and updated and the lookup colour
// is formed; the result is then held in the output register until the output
// side takes it. The sustained rate is one item per cycle as long as the output
// side keeps taking results. The colour word stores are flip-flop arrays
// cleared by reset, so no startup pass is needed.
module palette_register_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // reg_address, write_data, lookup_table, palette_number, color_index
  input  logic [pru_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_data, color
  output logic [pru_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import pru_pkg::*;

  // input register
  logic                in_valid_r;
  logic [1:0]          func_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [BYTE_W-1:0]   wdata_r;
  logic [TBL_W-1:0]    tbl_r;
  logic [PAL_W-1:0]    pal_r;
  logic [CI_W-1:0]     ci_r;

  // result register
  logic                out_valid_r;
  logic [BYTE_W-1:0]   rd_r;
  logic [RGB_W-1:0]    color_r;
  logic [BYTE_W-1:0]   rd_nxt;
  logic [RGB_W-1:0]    color_nxt;

  // palette state
  logic [BYTE_W-1:0]   mono_bg_r;
  logic [BYTE_W-1:0]   mono_obj0_r;
  logic [BYTE_W-1:0]   mono_obj1_r;
  logic [BYTE_W-1:0]   bg_lo_r  [COLOR_WORDS];
  logic [BYTE_W-1:0]   bg_hi_r  [COLOR_WORDS];
  logic [BYTE_W-1:0]   obj_lo_r [COLOR_WORDS];
  logic [BYTE_W-1:0]   obj_hi_r [COLOR_WORDS];
  logic [IDX_W-1:0]    bg_idx_r;
  logic                bg_inc_r;
  logic [IDX_W-1:0]    obj_idx_r;
  logic                obj_inc_r;

  logic                advance;
  logic                do_write;
  logic [WORD_AW-1:0]  bg_addr;
  logic [WORD_AW-1:0]  obj_addr;
  logic [RGB_W-1:0]    bg_word;
  logic [RGB_W-1:0]    obj_word;
  logic [RGB_W-1:0]    fix_word;
  logic [RGB_W-1:0]    fix_rgb;
  logic [1:0]          shade_bg;
  logic [1:0]          shade_obj0;
  logic [1:0]          shade_obj1;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign do_write   = advance && (func_r == FUNC_WRITE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {color_r, rd_r};

  always_comb begin
    if (func_r == FUNC_LOOKUP) begin
      bg_addr  = {pal_r, ci_r};
      obj_addr = {pal_r, ci_r};
    end else begin
      bg_addr  = bg_idx_r[IDX_W-1:1];
      obj_addr = obj_idx_r[IDX_W-1:1];
    end
    bg_word  = {bg_hi_r[bg_addr], bg_lo_r[bg_addr]};
    obj_word = {obj_hi_r[obj_addr], obj_lo_r[obj_addr]};
    fix_word = (tbl_r == TBL_COLOR_BG) ? bg_word : obj_word;
  end

  pru_color_fix u_color_fix (
    .word_i (fix_word),
    .rgb_o  (fix_rgb)
  );

  always_comb begin
    shade_bg   = mono_bg_r[{ci_r, 1'b0} +: 2];
    shade_obj0 = mono_obj0_r[{ci_r, 1'b0} +: 2];
    shade_obj1 = mono_obj1_r[{ci_r, 1'b0} +: 2];
    rd_nxt     = '0;
    color_nxt  = '0;
    case (func_r)
      FUNC_READ: begin
        case (addr_r)
          ADDR_BG_INDEX:  rd_nxt = {bg_inc_r, 1'b0, bg_idx_r};
          ADDR_BG_DATA:   rd_nxt = bg_idx_r[0] ? bg_word[15:8] : bg_word[7:0];
          ADDR_OBJ_INDEX: rd_nxt = {obj_inc_r, 1'b0, obj_idx_r};
          ADDR_OBJ_DATA:  rd_nxt = obj_idx_r[0] ? obj_word[15:8] : obj_word[7:0];
          default:        rd_nxt = '0;
        endcase
      end
      FUNC_LOOKUP: begin
        case (tbl_r)
          TBL_MONO_BG:   color_nxt = shade_rgb(shade_bg);
          TBL_MONO_OBJ0: color_nxt = shade_rgb(shade_obj0);
          TBL_MONO_OBJ1: color_nxt = shade_rgb(shade_obj1);
          TBL_COLOR_BG:  color_nxt = fix_rgb;
          TBL_COLOR_OBJ: color_nxt = fix_rgb;
          default:       color_nxt = '0;
        endcase
      end
      default: begin
        rd_nxt    = '0;
        color_nxt = '0;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      func_r  <= in_tuser;
      addr_r  <= in_tdata[15:0];
      wdata_r <= in_tdata[23:16];
      tbl_r   <= in_tdata[26:24];
      pal_r   <= in_tdata[29:27];
      ci_r    <= in_tdata[31:30];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      rd_r    <= rd_nxt;
      color_r <= color_nxt;
    end
  end

  // palette registers and index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_bg_r   <= MONO_RESET;
      mono_obj0_r <= MONO_RESET;
      mono_obj1_r <= MONO_RESET;
      bg_idx_r    <= '0;
      bg_inc_r    <= 1'b0;
      obj_idx_r   <= '0;
      obj_inc_r   <= 1'b0;
    end else if (do_write) begin
      case (addr_r)
        ADDR_MONO_BG:   mono_bg_r   <= wdata_r;
        ADDR_MONO_OBJ0: mono_obj0_r <= wdata_r;
        ADDR_MONO_OBJ1: mono_obj1_r <= wdata_r;
        ADDR_BG_INDEX: begin
          bg_idx_r <= wdata_r[IDX_W-1:0];
          bg_inc_r <= wdata_r[7];
        end
        ADDR_BG_DATA: begin
          if (bg_inc_r) begin
            bg_idx_r <= bg_idx_r + IDX_W'(1);
          end
        end
        ADDR_OBJ_INDEX: begin
          obj_idx_r <= wdata_r[IDX_W-1:0];
          obj_inc_r <= wdata_r[7];
        end
        ADDR_OBJ_DATA: begin
          if (obj_inc_r) begin
            obj_idx_r <= obj_idx_r + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // colour word stores, byte wide halves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COLOR_WORDS; i++) begin
        bg_lo_r[i]  <= '0;
        bg_hi_r[i]  <= '0;
        obj_lo_r[i] <= '0;
        obj_hi_r[i] <= '0;
      end
    end else if (do_write) begin
      if (addr_r == ADDR_BG_DATA) begin
        if (bg_idx_r[0]) begin
          bg_hi_r[bg_addr] <= wdata_r;
        end else begin
          bg_lo_r[bg_addr] <= wdata_r;
        end
      end
      if (addr_r == ADDR_OBJ_DATA) begin
        if (obj_idx_r[0]) begin
          obj_hi_r[obj_addr] <= wdata_r;
        end else begin
          obj_lo_r[obj_addr] <= wdata_r;
        end
      end
    end
  end

endmodule
